/* design/rrst_pkg.sv */
package rrst_pkg;

  // field widths of the item and result payloads
  localparam int BURST_W = 16;
  localparam int NUM_W   = 5;
  localparam int WAIT_W  = 20;
  localparam int SUM_W   = 24;
  localparam int Q_W     = 16;
  // internal time base, as wide as the sums
  localparam int TIME_W  = 24;

  // defaults for the top-level parameters
  localparam int MAX_PROCS_DEF  = 16;
  localparam int BURST_BITS_DEF = 16;

  localparam logic [Q_W-1:0] QUANTUM_RST = 16'd4;

  typedef struct packed {
    logic [BURST_W-1:0] burst_length;
    logic               final_process;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0]   process_number;
    logic [BURST_W-1:0] burst_echo;
    logic [WAIT_W-1:0]  wait_cycles;
    logic [WAIT_W-1:0]  finish_time;
    logic [SUM_W-1:0]   sum_wait;
    logic [SUM_W-1:0]   sum_finish;
    logic               end_of_report;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_POP,
    ST_FETCH,
    ST_TURN,
    ST_REP_RD,
    ST_REP_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic pop;
    logic fetch;
    logic turn;
    logic rep_rd;
    logic rep_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_last;
    logic turn_last;
    logic rep_last;
  } stat_t;

endpackage

/* design/rrst_ctrl.sv */
module rrst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rrst_pkg::stat_t stat,
  output logic            busy,
  output rrst_pkg::cmd_t  cmd
);
  import rrst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (stat.load_last) begin
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_TURN;
      end
      ST_TURN: begin
        cmd.turn  = 1'b1;
        state_nxt = stat.turn_last ? ST_REP_RD : ST_POP;
      end
      ST_REP_RD: begin
        cmd.rep_rd = 1'b1;
        state_nxt  = ST_REP_OUT;
      end
      ST_REP_OUT: begin
        cmd.rep_out = 1'b1;
        state_nxt   = stat.rep_last ? ST_LOAD : ST_REP_RD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

/* design/rrst_dp.sv */
module rrst_dp #(
  parameter int MAX_PROCS  = rrst_pkg::MAX_PROCS_DEF,
  parameter int BURST_BITS = rrst_pkg::BURST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rrst_pkg::cmd_t           cmd,
  input  rrst_pkg::in_item_t       in_data,
  input  logic                     cfg_we,
  input  logic [rrst_pkg::Q_W-1:0] cfg_data,
  output rrst_pkg::stat_t          stat,
  output logic                     out_valid,
  output rrst_pkg::out_item_t      out_data
);
  import rrst_pkg::*;

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int SB = (BURST_BITS < BURST_W) ? BURST_BITS : BURST_W;
  localparam int NW = (CW + 1 > NUM_W) ? CW + 1 : NUM_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);

  // ready queue of process indices and per-process stores
  logic [IW-1:0]     fifo_mem  [MAX_PROCS];
  logic [SB-1:0]     rem_mem   [MAX_PROCS];
  logic [SB-1:0]     burst_mem [MAX_PROCS];
  logic [TIME_W-1:0] fin_mem   [MAX_PROCS];

  logic [Q_W-1:0]    quantum_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     done_r;
  logic [IW-1:0]     head_r;
  logic [IW-1:0]     tail_r;
  logic [IW-1:0]     rep_idx_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [SUM_W-1:0]  sum_w_r;
  logic [SUM_W-1:0]  sum_f_r;
  logic              out_valid_r;
  out_item_t         out_r;

  // registered memory read data
  logic [IW-1:0]     fifo_q;
  logic [SB-1:0]     rem_q;
  logic [SB-1:0]     burst_q;
  logic [TIME_W-1:0] fin_q;

  logic [SB-1:0]     burst_in;
  logic [CW-1:0]     cnt_inc;
  logic [CW-1:0]     done_inc;
  logic [Q_W-1:0]    slice;
  logic [Q_W-1:0]    rem_ext;
  logic [Q_W-1:0]    run;
  logic [Q_W-1:0]    rem_left;
  logic              requeue;
  logic [TIME_W-1:0] elapsed_nxt;
  logic [TIME_W-1:0] wait_full;
  logic [NW-1:0]     num_wide;
  logic              fifo_we;
  logic [IW-1:0]     fifo_wa;
  logic [IW-1:0]     fifo_wd;
  logic              rem_we;
  logic [IW-1:0]     rem_wa;
  logic [SB-1:0]     rem_wd;

  // load side
  assign burst_in       = in_data.burst_length[SB-1:0];
  assign cnt_inc        = cnt_r + CW'(1);
  assign stat.load_last = in_data.final_process || (cnt_inc == CW'(MAX_PROCS));

  // one turn: run min(slice, remaining), advance time
  assign slice       = (quantum_r == '0) ? Q_W'(1) : quantum_r;
  assign rem_ext     = Q_W'(rem_q);
  assign run         = (rem_ext < slice) ? rem_ext : slice;
  assign rem_left    = rem_ext - run;
  assign requeue     = (rem_left != '0);
  assign elapsed_nxt = elapsed_r + TIME_W'(run);
  assign done_inc    = done_r + CW'(1);
  assign stat.turn_last = !requeue && (done_inc == cnt_r);

  // report side: waiting is completion minus burst
  assign stat.rep_last = ((CW'(rep_idx_r) + CW'(1)) == cnt_r);
  assign wait_full     = fin_q - TIME_W'(burst_q);
  assign num_wide      = NW'(rep_idx_r) + NW'(1);

  // single write port selects for queue and remaining store
  always_comb begin
    fifo_we = 1'b0;
    fifo_wa = tail_r;
    fifo_wd = fifo_q;
    rem_we  = 1'b0;
    rem_wa  = fifo_q;
    rem_wd  = rem_left[SB-1:0];
    if (cmd.load) begin
      fifo_we = 1'b1;
      fifo_wa = cnt_r[IW-1:0];
      fifo_wd = cnt_r[IW-1:0];
      rem_we  = 1'b1;
      rem_wa  = cnt_r[IW-1:0];
      rem_wd  = burst_in;
    end else if (cmd.turn) begin
      fifo_we = requeue;
      rem_we  = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= fifo_wd;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (cmd.load) begin
      burst_mem[cnt_r[IW-1:0]] <= burst_in;
    end
    if (cmd.turn && !requeue) begin
      fin_mem[fifo_q] <= elapsed_nxt;
    end
    if (cmd.pop) begin
      fifo_q <= fifo_mem[head_r];
    end
    if (cmd.fetch) begin
      rem_q <= rem_mem[fifo_q];
    end
    if (cmd.rep_rd) begin
      burst_q <= burst_mem[rep_idx_r];
      fin_q   <= fin_mem[rep_idx_r];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QUANTUM_RST;
      cnt_r       <= '0;
      done_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      rep_idx_r   <= '0;
      elapsed_r   <= '0;
      sum_w_r     <= '0;
      sum_f_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rep_out;
      if (cfg_we) begin
        quantum_r <= cfg_data;
      end
      if (cmd.load) begin
        cnt_r <= cnt_inc;
        if (stat.load_last) begin
          // set up the run over all loaded processes
          head_r    <= '0;
          tail_r    <= (cnt_inc == CW'(MAX_PROCS)) ? '0 : cnt_inc[IW-1:0];
          done_r    <= '0;
          elapsed_r <= '0;
          rep_idx_r <= '0;
          sum_w_r   <= '0;
          sum_f_r   <= '0;
        end
      end
      if (cmd.pop) begin
        head_r <= (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
      end
      if (cmd.turn) begin
        elapsed_r <= elapsed_nxt;
        if (requeue) begin
          tail_r <= (tail_r == LAST_IDX) ? '0 : tail_r + IW'(1);
        end else begin
          done_r <= done_inc;
        end
      end
      if (cmd.rep_out) begin
        sum_w_r <= sum_w_r + SUM_W'(wait_full);
        sum_f_r <= sum_f_r + SUM_W'(fin_q);
        if (stat.rep_last) begin
          rep_idx_r <= '0;
          cnt_r     <= '0;
        end else begin
          rep_idx_r <= rep_idx_r + IW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.rep_out) begin
      out_r.process_number <= num_wide[NUM_W-1:0];
      out_r.burst_echo     <= BURST_W'(burst_q);
      out_r.wait_cycles    <= wait_full[WAIT_W-1:0];
      out_r.finish_time    <= fin_q[WAIT_W-1:0];
      out_r.sum_wait       <= stat.rep_last ? sum_w_r + SUM_W'(wait_full) : '0;
      out_r.sum_finish     <= stat.rep_last ? sum_f_r + SUM_W'(fin_q) : '0;
      out_r.end_of_report  <= stat.rep_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/round_robin_schedule_timing.sv */
// Channel   Ports                              Transfer when
// -------   --------------------------------   -----------------------------
// input     start, busy, in_data               start high and busy low
// result    out_valid, out_data                out_valid high (one cycle)
// config    cfg_valid, cfg_ready, cfg_data     cfg_valid and cfg_ready high
//
// Loading takes one process per cycle; a non-final item gives no results.
// The final item (or the MAX_PROCS-th) starts the run: each round robin turn
// is a queue read, a remaining-store read and an update, and the number
// of turns is the sum over processes of max(1, ceil(burst / quantum)).
// The report then gives its results one by one, each by a burst/finish
// store read and the result register. busy stays high from the final item
// until the last result is shown; the next set may load in that same cycle.
// Reset (rst_n low, synchronous) sets quantum to 4 and empties the set.
// Results cannot be stalled by the receiver.
module round_robin_schedule_timing #(
  parameter int MAX_PROCS  = rrst_pkg::MAX_PROCS_DEF,
  parameter int BURST_BITS = rrst_pkg::BURST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  rrst_pkg::in_item_t       in_data,
  output logic                     out_valid,
  output rrst_pkg::out_item_t      out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [rrst_pkg::Q_W-1:0] cfg_data
);
  import rrst_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_accept;
  logic  cfg_we;

  assign in_accept = start && !busy;
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  rrst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rrst_dp #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // the last result of a report leaves the block ready for a new set
  a_eor_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_report |-> !busy)
    else $error("end of report shown while still busy");

  // results before the last one come while loading is blocked
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.end_of_report |-> busy)
    else $error("report result shown while accepting items");

  // a run only starts from an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(in_accept))
    else $error("busy rose without an input transfer");

endmodule
